### src/dpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_pkg
// Shared widths, register codes and types of the dual PID drive controller.
// ----------------------------------------------------------------------------
package dpid_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int INTEGRAL_BITS = 24;

  localparam int GAIN_W    = 16;
  localparam int BAND_W    = 10;
  localparam int LIMIT_W   = 7;
  localparam int DRIVE_W   = 8;
  localparam int FRAC_BITS = 12;

  // error = count - target, difference of two errors
  localparam int ERR_W  = COUNT_BITS + 1;
  localparam int DIFF_W = COUNT_BITS + 2;
  // integral update: widest of integral and error, plus carry
  localparam int ACC_W  = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;

  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PI_W  = GAIN_W + INTEGRAL_BITS;
  localparam int PD_W  = GAIN_W + DIFF_W;
  localparam int PMAX_W = (PI_W > PD_W) ? PI_W : PD_W;
  localparam int SUM_W  = PMAX_W + 2;

  localparam int IN_DATA_W  = ((2 * COUNT_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * DRIVE_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COUNT_BITS > GAIN_W) ? COUNT_BITS : GAIN_W;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd8192;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd164;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
  localparam logic [BAND_W-1:0]        BAND_RST   = 10'd50;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_TARGET  = 3'd3,
    REG_BAND    = 3'd4,
    REG_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]     gain_p;
    logic signed [GAIN_W-1:0]     gain_i;
    logic signed [GAIN_W-1:0]     gain_d;
    logic signed [COUNT_BITS-1:0] target_count;
    logic [BAND_W-1:0]            integral_band;
    logic [LIMIT_W-1:0]           drive_limit;
  } cfg_t;

  // pipeline strobes shared by both lanes
  typedef struct packed {
    logic update;  // accepted request while running: advance lane state
    logic adv1;    // stage 1 captures
    logic adv2;    // stage 2 captures
  } lane_ctrl_t;

  typedef struct packed {
    logic stopped; // request arrived after finish: repeat held drives
    logic done;
  } item_tag_t;

endpackage

### src/dpid_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_lane
// One wheel's PID: error, integral zone and derivative state, gain
// products, then scaling and clamping of the drive.
// ----------------------------------------------------------------------------
module dpid_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dpid_pkg::lane_ctrl_t                  ctrl,
  input  dpid_pkg::cfg_t                        cfg,
  input  logic signed [dpid_pkg::COUNT_BITS-1:0] count,
  output logic signed [dpid_pkg::DRIVE_W-1:0]   drive
);
  import dpid_pkg::*;

  localparam logic signed [ACC_W-1:0] IMAX =
    ACC_W'((64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] IMIN = -IMAX - ACC_W'(1);
  localparam logic signed [SUM_W-1:0] ROUND_ADJ = SUM_W'((1 << FRAC_BITS) - 1);

  // loop state
  logic signed [ERR_W-1:0]         prev_err_r;
  logic signed [INTEGRAL_BITS-1:0] integ_r, integ_nxt;

  // stage 1
  logic signed [ERR_W-1:0]         s1_err_r;
  logic signed [INTEGRAL_BITS-1:0] s1_integ_r;
  logic signed [DIFF_W-1:0]        s1_diff_r;

  // stage 2
  logic signed [PP_W-1:0] s2_pp_r;
  logic signed [PI_W-1:0] s2_pi_r;
  logic signed [PD_W-1:0] s2_pd_r;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  band_s;
  logic                     in_band;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;

  logic signed [SUM_W-1:0] sum, adj, quo, lim_s, clamped;

  always_comb begin
    err    = ERR_W'(count) - ERR_W'(cfg.target_count);
    band_s = $signed(ERR_W'(cfg.integral_band));
    in_band = (err < band_s) && (err > -band_s);
    acc    = ACC_W'(integ_r) + ACC_W'(err);
    if ((cfg.gain_i == '0) || !in_band) begin
      integ_nxt = '0;
    end else if (acc > IMAX) begin
      integ_nxt = INTEGRAL_BITS'(IMAX);
    end else if (acc < IMIN) begin
      integ_nxt = INTEGRAL_BITS'(IMIN);
    end else begin
      integ_nxt = INTEGRAL_BITS'(acc);
    end
    diff = DIFF_W'(err) - DIFF_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (ctrl.update) begin
      prev_err_r <= err;
      integ_r    <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      s1_err_r   <= err;
      s1_integ_r <= integ_nxt;
      s1_diff_r  <= diff;
    end
    if (ctrl.adv2) begin
      s2_pp_r <= PP_W'(cfg.gain_p) * PP_W'(s1_err_r);
      s2_pi_r <= PI_W'(cfg.gain_i) * PI_W'(s1_integ_r);
      s2_pd_r <= PD_W'(cfg.gain_d) * PD_W'(s1_diff_r);
    end
  end

  // divide by 4096 truncating toward zero, then clamp
  always_comb begin
    sum   = SUM_W'(s2_pp_r) + SUM_W'(s2_pi_r) + SUM_W'(s2_pd_r);
    adj   = sum[SUM_W-1] ? (sum + ROUND_ADJ) : sum;
    quo   = adj >>> FRAC_BITS;
    lim_s = $signed(SUM_W'(cfg.drive_limit));
    if (quo > lim_s) begin
      clamped = lim_s;
    end else if (quo < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = quo;
    end
    drive = DRIVE_W'(clamped);
  end

endmodule

### src/dpid_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_merge
// Joins both lanes into one result: left negation, held drives after
// finish, done flag, and the output register.
// ----------------------------------------------------------------------------
module dpid_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  dpid_pkg::item_tag_t                 tag,
  input  logic signed [dpid_pkg::DRIVE_W-1:0] drv_left,
  input  logic signed [dpid_pkg::DRIVE_W-1:0] drv_right,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dpid_pkg::DRIVE_W-1:0] drive_left,
  output logic signed [dpid_pkg::DRIVE_W-1:0] drive_right,
  output logic                                done
);
  import dpid_pkg::*;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] drive_left_r, drive_right_r;
  logic signed [DRIVE_W-1:0] held_left_r, held_right_r;
  logic signed [DRIVE_W-1:0] left_nxt, right_nxt;
  logic                      done_r;
  logic                      load;

  always_comb begin
    in_ready = !out_valid_r || out_ready;
    load     = in_valid && in_ready;
    left_nxt  = tag.stopped ? held_left_r  : -drv_left;
    right_nxt = tag.stopped ? held_right_r : drv_right;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      held_left_r  <= '0;
      held_right_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        held_left_r  <= left_nxt;
        held_right_r <= right_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_left_r  <= left_nxt;
      drive_right_r <= right_nxt;
      done_r        <= tag.done;
    end
  end

  assign out_valid   = out_valid_r;
  assign drive_left  = drive_left_r;
  assign drive_right = drive_right_r;
  assign done        = done_r;

endmodule

### src/dual_pid_drive_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pid_drive_controller_unit
// Two-lane PID drive controller with integral zone and finish detection.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes the error/integral stage, the multiply
//   stage and the scale/clamp/output stage before its result shows at out_tvalid.
// Throughput: one request per cycle while out_tready does not stall the output;
//   the integral and last-error update is a single add/compare, so ticks never wait on it.
// Reset (rst_n low, synchronous): registers back to defaults, integrals and
//   last errors zero, controller running, pipeline empty.
module dual_pid_drive_controller_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: left_count, right_count
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [dpid_pkg::IN_DATA_W-1:0]        in_tdata,
  // out_tdata: drive_left, drive_right
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dpid_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser: done_res
  output logic                                  out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dpid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpid_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dpid_pkg::*;

  cfg_t       cfg_r;
  lane_ctrl_t ctrl;
  item_tag_t  tag_in, tag1_r, tag2_r;
  logic       v1_r, v2_r;
  logic       running_r;
  logic       go_o, go1, go2, accept, finish;

  logic signed [COUNT_BITS-1:0] left_count, right_count;
  logic signed [DRIVE_W-1:0]    drv_left, drv_right, drive_left, drive_right;
  logic                         done_res;

  assign left_count  = $signed(in_tdata[COUNT_BITS-1:0]);
  assign right_count = $signed(in_tdata[2*COUNT_BITS-1:COUNT_BITS]);

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p        <= GAIN_P_RST;
      cfg_r.gain_i        <= GAIN_I_RST;
      cfg_r.gain_d        <= GAIN_D_RST;
      cfg_r.target_count  <= '0;
      cfg_r.integral_band <= BAND_RST;
      cfg_r.drive_limit   <= LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P: cfg_r.gain_p        <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_I: cfg_r.gain_i        <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_D: cfg_r.gain_d        <= $signed(cfg_data[GAIN_W-1:0]);
        REG_TARGET: cfg_r.target_count  <= $signed(cfg_data[COUNT_BITS-1:0]);
        REG_BAND:   cfg_r.integral_band <= cfg_data[BAND_W-1:0];
        REG_LIMIT:  cfg_r.drive_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  always_comb begin
    go2    = !v2_r || go_o;
    go1    = !v1_r || go2;
    accept = in_tvalid && go1;
    finish = (cfg_r.target_count >= left_count) && (cfg_r.target_count >= right_count);
    ctrl.update = accept && running_r;
    ctrl.adv1   = go1;
    ctrl.adv2   = go2;
    tag_in.stopped = !running_r;
    tag_in.done    = !running_r || finish;
  end

  assign in_tready = go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      running_r <= 1'b1;
    end else begin
      if (go1) begin
        v1_r <= accept;
      end
      if (go2) begin
        v2_r <= v1_r;
      end
      if (ctrl.update && finish) begin
        running_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      tag1_r <= tag_in;
    end
    if (go2) begin
      tag2_r <= tag1_r;
    end
  end

  dpid_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .cfg   (cfg_r),
    .count (left_count),
    .drive (drv_left)
  );

  dpid_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .cfg   (cfg_r),
    .count (right_count),
    .drive (drv_right)
  );

  dpid_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v2_r),
    .tag         (tag2_r),
    .drv_left    (drv_left),
    .drv_right   (drv_right),
    .in_ready    (go_o),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .drive_left  (drive_left),
    .drive_right (drive_right),
    .done        (done_res)
  );

  assign out_tdata = {drive_right, drive_left};
  assign out_tuser = done_res;

endmodule

### src/dpid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_checker
// Port-level checks of the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module dpid_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dpid_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import dpid_pkg::*;

  logic                  done_seen_r;
  logic [OUT_DATA_W-1:0] last_data_r;
  logic                  out_acc;

  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r <= 1'b0;
    end else if (out_acc && out_tuser) begin
      done_seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc && out_tuser) begin
      last_data_r <= out_tdata;
    end
  end

  // stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // after finish every result repeats the finishing drives with done set
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && done_seen_r |-> out_tuser && (out_tdata == last_data_r))
    else $error("result after finish differs from held drives");

  // clamp keeps both drives within +-127
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DRIVE_W-1:0] != 8'h80) &&
                   (out_tdata[OUT_DATA_W-1:DRIVE_W] != 8'h80))
    else $error("drive outside clamp range");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind dual_pid_drive_controller_unit dpid_checker u_dpid_checker (.*);
